FILE: rtl/pmst_pkg.sv
// Shared types, constants and address helper for the Prim spanning tree block.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package pmst_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VW           = 6;
    localparam int WW           = 15;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int MEM_DEPTH    = MAX_VERTICES * MAX_VERTICES;
    localparam int ADDR_W       = $clog2(MEM_DEPTH);
    localparam int STEP_W       = VW + 1;

    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = PADDR_W - 2;

    localparam logic [WW-1:0]        NO_EDGE          = WW'(32767);
    localparam logic                 REQ_EDGE         = 1'b0;
    localparam logic                 REQ_RUN          = 1'b1;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = REG_IDX_W'(0);
    localparam logic [VW-1:0]        VCOUNT_RESET     = VW'(1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE2,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_STEP,
        ST_SCAN,
        ST_PICK,
        ST_RELAX_RD,
        ST_RELAX_WR,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WW-1:0]     wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } adj_req_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [VW-1:0] a,
                                                    input logic [VW-1:0] b);
        logic [VW-1:0] a_dec;
        logic [VW-1:0] b_dec;
        a_dec = a - VW'(1);
        b_dec = b - VW'(1);
        return ADDR_W'(ADDR_W'(a_dec) * ADDR_W'(MAX_VERTICES) + ADDR_W'(b_dec));
    endfunction

endpackage

FILE: rtl/pmst_adj_mem.sv
// Adjacency weight memory: one write port and one registered read port.
// Depends on pmst_pkg.
`timescale 1ns / 1ps

module pmst_adj_mem
    import pmst_pkg::*;
(
    input  logic          clk,
    input  adj_req_t      req,
    output logic [WW-1:0] rd_data
);

    logic [WW-1:0] adj_mem [MEM_DEPTH];
    logic [WW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            adj_mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= adj_mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/prim_minimum_spanning_tree.sv
// Prim minimum spanning tree over an adjacency matrix held in a memory with one write port and one read port.
// Depends on pmst_pkg and pmst_adj_mem.
//
// After reset the block sweeps the 1024-entry weight memory to no-edge, one entry per cycle,
// and holds req_ready low during the sweep; configuration writes are taken meanwhile.
// An edge beat makes one memory write per direction. A run beat reads the matrix through
// one memory read port with a registered output, so each matrix read has a read state and
// a capture state, and the lowest-cost scan compares one vertex per cycle.
// Each tree edge and the closing end beat wait in an output register, so a stalled
// result only holds the sequencer when the next result is due. Once the end beat is
// loaded the block sweeps the matrix back to no-edge, again with req_ready low.
`timescale 1ns / 1ps

module prim_minimum_spanning_tree
    import pmst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_ready,
    input  logic               req_type,
    input  logic [VW-1:0]      vertex_a,
    input  logic [VW-1:0]      vertex_b,
    input  logic [WW-1:0]      edge_weight,
    // result channel
    output logic               res_valid,
    input  logic               res_ready,
    output logic [VW-1:0]      parent_vertex,
    output logic [VW-1:0]      child_vertex,
    output logic [WW-1:0]      tree_weight,
    output logic               is_edge,
    output logic               last,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    seq_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [VW-1:0]       vertex_count_reg;
    logic [MAX_VERTICES-1:0] in_tree_reg;
    logic                out_valid_reg;

    logic [VW-1:0]       a_reg, b_reg, n_reg, j_reg, k_reg;
    logic [WW-1:0]       w_reg, low_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [WW-1:0]       best_cost_reg [MAX_VERTICES];
    logic [VW-1:0]       nearest_reg   [MAX_VERTICES];
    logic [VW-1:0]       parent_reg, child_reg;
    logic [WW-1:0]       weight_reg;
    logic                is_edge_reg, last_reg;

    logic [VW-1:0]       n_eff;
    logic                edge_ok;
    logic                cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [VW-1:0]       j_dec, k_dec;
    logic [IDX_W-1:0]    j_idx, k_idx;
    logic                j_last;
    logic                emit_ok;
    logic                load_edge, load_end;
    logic [VW-1:0]       rd_row;
    logic [WW-1:0]       rd_data;
    adj_req_t            mem_req;

    assign n_eff   = (vertex_count_reg > VW'(MAX_VERTICES)) ? VW'(MAX_VERTICES)
                                                            : vertex_count_reg;
    assign edge_ok = (vertex_a != '0) && (vertex_b != '0)
                     && (vertex_a <= n_eff) && (vertex_b <= n_eff);
    assign j_dec   = j_reg - VW'(1);
    assign k_dec   = k_reg - VW'(1);
    assign j_idx   = j_dec[IDX_W-1:0];
    assign k_idx   = k_dec[IDX_W-1:0];
    assign j_last  = (j_reg == n_reg);
    assign emit_ok = !out_valid_reg || res_ready;

    // configuration port
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_VERTEX_COUNT)
        begin
            prdata = PDATA_W'(vertex_count_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_type == REQ_EDGE)
                    begin
                        if (edge_ok)
                        begin
                            state_next = ST_EDGE2;
                        end
                    end
                    else if (n_eff == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_INIT_RD;
                    end
                end
            end
            ST_EDGE2:    state_next = ST_IDLE;
            ST_INIT_RD:  state_next = ST_INIT_WR;
            ST_INIT_WR:  state_next = j_last ? ST_STEP : ST_INIT_RD;
            ST_STEP:
            begin
                state_next = (step_reg <= STEP_W'(n_reg)) ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN:     state_next = j_last ? ST_PICK : ST_SCAN;
            ST_PICK:
            begin
                if (k_reg == '0)
                begin
                    state_next = ST_STEP;
                end
                else if (emit_ok)
                begin
                    state_next = ST_RELAX_RD;
                end
            end
            ST_RELAX_RD: state_next = ST_RELAX_WR;
            ST_RELAX_WR: state_next = j_last ? ST_STEP : ST_RELAX_RD;
            ST_FINISH:
            begin
                if (emit_ok)
                begin
                    state_next = ST_CLEAR;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req_ready       = 1'b0;
        load_edge       = 1'b0;
        load_end        = 1'b0;
        rd_row          = (state_reg == ST_INIT_RD) ? VW'(1) : k_reg;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = cell_addr(vertex_a, vertex_b);
        mem_req.wr_data = edge_weight;
        mem_req.rd_addr = cell_addr(rd_row, j_reg);
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_addr_reg;
                mem_req.wr_data = NO_EDGE;
            end
            ST_IDLE:
            begin
                req_ready     = 1'b1;
                mem_req.wr_en = req_valid && (req_type == REQ_EDGE) && edge_ok;
            end
            ST_EDGE2:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cell_addr(b_reg, a_reg);
                mem_req.wr_data = w_reg;
            end
            ST_PICK:
            begin
                load_edge = (k_reg != '0) && emit_ok;
            end
            ST_FINISH:
            begin
                load_end = emit_ok;
            end
            ST_INIT_RD, ST_INIT_WR, ST_STEP, ST_SCAN, ST_RELAX_RD, ST_RELAX_WR:
            begin
            end
            default:
            begin
            end
        endcase
    end

    pmst_adj_mem u_adj_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            vertex_count_reg <= VCOUNT_RESET;
            in_tree_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cfg_wr && (reg_idx == REG_VERTEX_COUNT))
            begin
                vertex_count_reg <= pwdata[VW-1:0];
            end
            if ((state_reg == ST_IDLE) && req_valid && (req_type == REQ_RUN))
            begin
                in_tree_reg[0] <= 1'b1;
            end
            if (load_edge)
            begin
                in_tree_reg[k_idx] <= 1'b1;
            end
            if (load_end)
            begin
                in_tree_reg <= '0;
            end
            if (load_edge || load_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    a_reg <= vertex_a;
                    b_reg <= vertex_b;
                    w_reg <= edge_weight;
                    n_reg <= n_eff;
                    j_reg <= VW'(1);
                end
            end
            ST_INIT_WR:
            begin
                best_cost_reg[j_idx] <= rd_data;
                nearest_reg[j_idx]   <= VW'(1);
                if (j_last)
                begin
                    step_reg <= STEP_W'(2);
                end
                else
                begin
                    j_reg <= j_reg + VW'(1);
                end
            end
            ST_STEP:
            begin
                j_reg   <= VW'(1);
                low_reg <= NO_EDGE;
                k_reg   <= '0;
            end
            ST_SCAN:
            begin
                if (!in_tree_reg[j_idx] && (best_cost_reg[j_idx] < low_reg))
                begin
                    low_reg <= best_cost_reg[j_idx];
                    k_reg   <= j_reg;
                end
                if (!j_last)
                begin
                    j_reg <= j_reg + VW'(1);
                end
            end
            ST_PICK:
            begin
                if (k_reg == '0)
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
                if (load_edge)
                begin
                    j_reg <= VW'(1);
                end
            end
            ST_RELAX_WR:
            begin
                if (!in_tree_reg[j_idx] && (rd_data < best_cost_reg[j_idx]))
                begin
                    best_cost_reg[j_idx] <= rd_data;
                    nearest_reg[j_idx]   <= k_reg;
                end
                if (j_last)
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + VW'(1);
                end
            end
            ST_CLEAR, ST_EDGE2, ST_INIT_RD, ST_RELAX_RD, ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase

        if (load_edge)
        begin
            parent_reg  <= nearest_reg[k_idx];
            child_reg   <= k_reg;
            weight_reg  <= low_reg;
            is_edge_reg <= 1'b1;
            last_reg    <= 1'b0;
        end
        else if (load_end)
        begin
            parent_reg  <= '0;
            child_reg   <= '0;
            weight_reg  <= '0;
            is_edge_reg <= 1'b0;
            last_reg    <= 1'b1;
        end
    end

    assign res_valid     = out_valid_reg;
    assign parent_vertex = parent_reg;
    assign child_vertex  = child_reg;
    assign tree_weight   = weight_reg;
    assign is_edge       = is_edge_reg;
    assign last          = last_reg;

endmodule

FILE: rtl/pmst_checker.sv
// Port-level assertions for prim_minimum_spanning_tree, attached by bind.
// Depends on pmst_pkg and the top level's port list.
`timescale 1ns / 1ps

module pmst_checker
    import pmst_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_ready,
    input logic          res_valid,
    input logic          res_ready,
    input logic [VW-1:0] parent_vertex,
    input logic [VW-1:0] child_vertex,
    input logic [WW-1:0] tree_weight,
    input logic          is_edge,
    input logic          last
);

    // hold a stalled result beat
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(parent_vertex)
            && $stable(child_vertex) && $stable(tree_weight) && $stable(is_edge)
            && $stable(last))
        else $error("result beat changed while stalled");

    a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && last |-> !is_edge && (parent_vertex == '0)
            && (child_vertex == '0) && (tree_weight == '0))
        else $error("end beat carries nonzero fields");

    a_edge_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_edge |-> !last && (child_vertex != '0)
            && (parent_vertex != '0) && (child_vertex != parent_vertex)
            && (tree_weight != NO_EDGE))
        else $error("malformed tree edge beat");

    a_busy_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_edge |-> !req_ready)
        else $error("request taken while a run is still emitting edges");

endmodule

bind prim_minimum_spanning_tree pmst_checker u_pmst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_ready     (req_ready),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .parent_vertex (parent_vertex),
    .child_vertex  (child_vertex),
    .tree_weight   (tree_weight),
    .is_edge       (is_edge),
    .last          (last)
);
